// ===== rtl/trd_pkg.sv =====
// Shared types and constants for the TDC readout packet decoder.
package trd_pkg;

    localparam int MODULES           = 26;
    localparam int CHANS_PER_MODULE  = 32;
    localparam int CHAN_LIMIT        = MODULES * CHANS_PER_MODULE;
    localparam int CHANS_PER_ROW     = 4;
    localparam int ROWS              = CHAN_LIMIT / CHANS_PER_ROW;
    localparam int ROW_W             = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int LIMIT_W           = 11;

    localparam int CMD_DEPTH         = 4;
    localparam int CMD_PTR_W         = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W         = $clog2(CMD_DEPTH + 1);
    localparam int RES_DEPTH         = 4;
    localparam int RES_PTR_W         = $clog2(RES_DEPTH);
    localparam int RES_CNT_W         = $clog2(RES_DEPTH + 1);

    localparam logic [9:0]  CHAN_COUNT     = 10'(CHAN_LIMIT);
    localparam logic [5:0]  TDC_SUPPRESSED = 6'd43;
    localparam logic [6:0]  CHAN_CLEAR     = {1'b0, TDC_SUPPRESSED};
    localparam logic [13:0] PAIR_CLEAR     = {CHAN_CLEAR, CHAN_CLEAR};

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_READ = 1'b1;

    localparam logic [3:0] TAG_MODULE = 4'h4;
    localparam logic [3:0] TAG_EVENT  = 4'h5;
    localparam logic [3:0] TAG_CLOCK  = 4'h6;

    localparam logic [1:0] HDR_MODULE = 2'd0;
    localparam logic [1:0] HDR_EVENT  = 2'd1;
    localparam logic [1:0] HDR_CLOCK  = 2'd2;

    localparam logic [5:0] FPGA_ADDR_MIN = 6'd6;

    typedef struct packed {
        logic        op;
        logic [31:0] data_word;
        logic        last;
        logic [9:0]  channel;
    } in_item_t;

    typedef struct packed {
        logic [5:0]  tdc_value;
        logic        trigger_bit;
        logic        packet_ok;
        logic [11:0] module_address;
        logic [11:0] event_number;
        logic [11:0] clock_number;
        logic [15:0] parity_word;
        logic        parity_good;
        logic        event_match;
        logic [9:0]  channel_count;
    } out_item_t;

    // Decoded command handed from the front end to the execution side.
    typedef struct packed {
        logic             is_read;
        logic             clear;
        logic             hdr_wr;
        logic [1:0]       hdr_sel;
        logic [11:0]      hdr_val;
        logic             pair_wr;
        logic [ROW_W-1:0] row;
        logic             lane;
        logic [13:0]      pair_data;
        logic             trailer;
        logic             trailer_ok;
        logic [17:0]      trailer_bits;
        logic             rd_half;
        logic             rd_in_range;
    } cmd_t;

endpackage

// ===== rtl/tdc_readout_packet_decoder.sv =====
// Top level of the TDC readout packet decoder.
// Items enter through a push/full queue port: op 0 pushes one packet word
// (last marks the trailer), op 1 reads one channel and yields one result on
// the empty/pop side; pushes yield none. One item per clock is accepted
// sustained while the command queue is not full; a read result passes the
// read stage register and then the result queue, and reads pause only while
// the four-entry result queue could overfill. The channel store clears at the
// first word of each packet through per-row valid bits, so there is no
// clearing sweep after reset or between packets. Reads during a packet in
// progress, or after a bad trailer, return all zeros.
module tdc_readout_packet_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  trd_pkg::in_item_t  item,
    output logic               empty,
    input  logic               pop,
    output trd_pkg::out_item_t result
);
    import trd_pkg::*;

    logic accept;
    cmd_t dec_cmd;
    cmd_t head_cmd;
    logic cmd_empty;
    logic cmd_pop;

    assign accept = push && !full;

    trd_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .cmd    (dec_cmd)
    );

    trd_cmd_queue u_cmd_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept),
        .wr_cmd (dec_cmd),
        .full   (full),
        .rd_en  (cmd_pop),
        .rd_cmd (head_cmd),
        .empty  (cmd_empty)
    );

    trd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (head_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (result)
    );

endmodule

// ===== rtl/trd_front.sv =====
// Front end: tracks packet word position and decodes each item into a command.
module trd_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  trd_pkg::in_item_t item,
    output trd_pkg::cmd_t    cmd
);
    import trd_pkg::*;

    localparam logic [1:0] POS_SAT = 2'd3;

    logic [1:0]  pos_reg;
    logic [1:0]  pos_next;
    logic        fmt_reg;
    logic        fmt_next;

    logic        first;
    logic        fmt_eff;
    logic [31:0] w;
    logic [3:0]  tag;
    logic        tag_ok;
    logic [5:0]  fpga_addr;
    logic        addr_ok;
    logic [3:0]  module_idx;
    logic [9:0]  base;
    logic        base_ok;
    logic        ch_ok;

    assign w          = item.data_word;
    assign first      = (pos_reg == 2'd0);
    assign fmt_eff    = first ? w[30] : fmt_reg;
    assign tag        = w[15:12];
    assign tag_ok     = (tag == TAG_MODULE) || (tag == TAG_EVENT) || (tag == TAG_CLOCK);
    assign fpga_addr  = w[26:21];
    assign addr_ok    = !fpga_addr[5] && (fpga_addr >= FPGA_ADDR_MIN);
    // (31 - addr) >> 1 for a 5-bit address is the inverted upper four bits
    assign module_idx = ~fpga_addr[4:1];
    assign base       = {module_idx, w[20:16], 1'b0};
    assign base_ok    = ({1'b0, base} < LIMIT_W'(CHAN_LIMIT));
    assign ch_ok      = ({1'b0, item.channel} < LIMIT_W'(CHAN_LIMIT));

    always_comb
    begin
        cmd = '0;
        unique case (item.op)
            OP_PUSH:
            begin
                cmd.clear        = first;
                cmd.hdr_wr       = (pos_reg != POS_SAT) && fmt_eff && w[29] && tag_ok;
                cmd.hdr_sel      = 2'(tag - TAG_MODULE);
                cmd.hdr_val      = w[11:0];
                cmd.pair_wr      = (pos_reg == POS_SAT) && !item.last && fmt_eff
                                   && addr_ok && base_ok;
                cmd.row          = base[ROW_W+1:2];
                cmd.lane         = base[1];
                cmd.pair_data    = {w[13], w[11:6], w[12], w[5:0]};
                cmd.trailer      = item.last;
                cmd.trailer_ok   = w[31] && (pos_reg >= 2'd2);
                cmd.trailer_bits = w[17:0];
            end
            OP_READ:
            begin
                cmd.is_read      = 1'b1;
                cmd.row          = item.channel[ROW_W+1:2];
                cmd.lane         = item.channel[1];
                cmd.rd_half      = item.channel[0];
                cmd.rd_in_range  = ch_ok;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        fmt_next = fmt_reg;
        if (accept && (item.op == OP_PUSH))
        begin
            if (first)
            begin
                fmt_next = w[30];
            end
            if (item.last)
            begin
                pos_next = 2'd0;
            end
            else if (pos_reg != POS_SAT)
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= 2'd0;
            fmt_reg <= 1'b0;
        end
        else
        begin
            pos_reg <= pos_next;
            fmt_reg <= fmt_next;
        end
    end

endmodule

// ===== rtl/trd_cmd_queue.sv =====
// Short command queue between the decode front end and the execution back end.
module trd_cmd_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  trd_pkg::cmd_t  wr_cmd,
    output logic           full,
    input  logic           rd_en,
    output trd_pkg::cmd_t  rd_cmd,
    output logic           empty
);
    import trd_pkg::*;

    cmd_t                 slot_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg;
    logic [CMD_PTR_W-1:0] wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg;
    logic [CMD_PTR_W-1:0] rd_ptr_next;
    logic [CMD_CNT_W-1:0] cnt_reg;
    logic [CMD_CNT_W-1:0] cnt_next;
    logic                 do_wr;
    logic                 do_rd;

    assign full   = (cnt_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty  = (cnt_reg == '0);
    assign rd_cmd = slot_reg[rd_ptr_reg];
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                    : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == CMD_PTR_W'(CMD_DEPTH - 1)) ? '0
                                                                    : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slot_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

endmodule

// ===== rtl/trd_back.sv =====
// Back end: channel store, header/trailer state, read pipeline and result queue.
module trd_back (
    input  logic              clk,
    input  logic              rst_n,
    input  trd_pkg::cmd_t     cmd,
    input  logic              cmd_empty,
    output logic              cmd_pop,
    output logic              empty,
    input  logic              pop,
    output trd_pkg::out_item_t result
);
    import trd_pkg::*;

    // Store is two lane memories of channel pairs; a row holds four channels
    // and one valid bit, so a cleared row reads as suppressed.
    logic [13:0]          mem_lo [ROWS];
    logic [13:0]          mem_hi [ROWS];
    logic [ROWS-1:0]      row_valid_reg;
    logic [ROWS-1:0]      row_valid_next;

    logic [11:0]          hdr_reg [3];
    logic [11:0]          hdr_next [3];
    logic [17:0]          trailer_reg;
    logic [17:0]          trailer_next;
    logic                 valid_flag_reg;
    logic                 valid_flag_next;

    logic                 issue;
    logic                 issue_word;
    logic                 issue_read;
    logic                 room;
    logic                 row_valid_cur;
    logic                 wr_lo;
    logic                 wr_hi;
    logic [13:0]          wr_lo_data;
    logic [13:0]          wr_hi_data;

    logic                 s_valid_reg;
    logic [13:0]          rd_lo_reg;
    logic [13:0]          rd_hi_reg;
    logic                 s_row_valid_reg;
    logic                 s_lane_reg;
    logic                 s_half_reg;
    logic                 s_in_range_reg;
    out_item_t            s_info_reg;
    out_item_t            info;
    out_item_t            res_item;
    logic [13:0]          s_pair;
    logic [6:0]           s_chan;

    out_item_t            res_slot_reg [RES_DEPTH];
    logic [RES_PTR_W-1:0] res_wr_ptr_reg;
    logic [RES_PTR_W-1:0] res_rd_ptr_reg;
    logic [RES_CNT_W-1:0] res_cnt_reg;
    logic [RES_CNT_W-1:0] res_cnt_next;
    logic                 res_pop;

    // a read is only issued when its result is sure to find a queue slot
    assign room       = ({1'b0, res_cnt_reg} + (RES_CNT_W + 1)'(s_valid_reg))
                        < (RES_CNT_W + 1)'(RES_DEPTH);
    assign issue      = !cmd_empty && (!cmd.is_read || room);
    assign issue_word = issue && !cmd.is_read;
    assign issue_read = issue && cmd.is_read;
    assign cmd_pop    = issue;

    assign row_valid_cur = row_valid_reg[cmd.row];
    assign wr_lo      = issue_word && cmd.pair_wr && (!cmd.lane || !row_valid_cur);
    assign wr_hi      = issue_word && cmd.pair_wr && (cmd.lane || !row_valid_cur);
    assign wr_lo_data = cmd.lane ? PAIR_CLEAR : cmd.pair_data;
    assign wr_hi_data = cmd.lane ? cmd.pair_data : PAIR_CLEAR;

    always_comb
    begin
        row_valid_next  = row_valid_reg;
        hdr_next        = hdr_reg;
        trailer_next    = trailer_reg;
        valid_flag_next = valid_flag_reg;
        if (issue_word)
        begin
            if (cmd.clear)
            begin
                row_valid_next  = '0;
                hdr_next[0]     = '0;
                hdr_next[1]     = '0;
                hdr_next[2]     = '0;
                valid_flag_next = 1'b0;
            end
            if (cmd.hdr_wr)
            begin
                if (cmd.hdr_sel == HDR_MODULE)
                begin
                    hdr_next[0] = cmd.hdr_val;
                end
                if (cmd.hdr_sel == HDR_EVENT)
                begin
                    hdr_next[1] = cmd.hdr_val;
                end
                if (cmd.hdr_sel == HDR_CLOCK)
                begin
                    hdr_next[2] = cmd.hdr_val;
                end
            end
            if (cmd.pair_wr)
            begin
                row_valid_next[cmd.row] = 1'b1;
            end
            if (cmd.trailer)
            begin
                valid_flag_next = cmd.trailer_ok;
                trailer_next    = cmd.trailer_bits;
            end
        end
    end

    // header and trailer fields are sampled when the read issues
    always_comb
    begin
        info = '0;
        if (valid_flag_reg)
        begin
            info.packet_ok      = 1'b1;
            info.module_address = hdr_reg[HDR_MODULE];
            info.event_number   = hdr_reg[HDR_EVENT];
            info.clock_number   = hdr_reg[HDR_CLOCK];
            info.parity_word    = trailer_reg[15:0];
            info.parity_good    = trailer_reg[16];
            info.event_match    = trailer_reg[17];
            info.channel_count  = CHAN_COUNT;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg  <= '0;
            hdr_reg[0]     <= '0;
            hdr_reg[1]     <= '0;
            hdr_reg[2]     <= '0;
            trailer_reg    <= '0;
            valid_flag_reg <= 1'b0;
            s_valid_reg    <= 1'b0;
        end
        else
        begin
            row_valid_reg  <= row_valid_next;
            hdr_reg        <= hdr_next;
            trailer_reg    <= trailer_next;
            valid_flag_reg <= valid_flag_next;
            s_valid_reg    <= issue_read;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_lo)
        begin
            mem_lo[cmd.row] <= wr_lo_data;
        end
        if (wr_hi)
        begin
            mem_hi[cmd.row] <= wr_hi_data;
        end
        if (issue_read)
        begin
            rd_lo_reg       <= mem_lo[cmd.row];
            rd_hi_reg       <= mem_hi[cmd.row];
            s_row_valid_reg <= row_valid_cur;
            s_lane_reg      <= cmd.lane;
            s_half_reg      <= cmd.rd_half;
            s_in_range_reg  <= cmd.rd_in_range;
            s_info_reg      <= info;
        end
    end

    assign s_pair = s_lane_reg ? rd_hi_reg : rd_lo_reg;
    assign s_chan = !s_row_valid_reg ? CHAN_CLEAR
                  : (s_half_reg ? s_pair[13:7] : s_pair[6:0]);

    always_comb
    begin
        res_item = s_info_reg;
        if (s_info_reg.packet_ok && s_in_range_reg)
        begin
            res_item.tdc_value   = s_chan[5:0];
            res_item.trigger_bit = s_chan[6];
        end
    end

    // result queue
    assign empty   = (res_cnt_reg == '0);
    assign result  = res_slot_reg[res_rd_ptr_reg];
    assign res_pop = pop && !empty;

    always_comb
    begin
        res_cnt_next = res_cnt_reg;
        if (s_valid_reg && !res_pop)
        begin
            res_cnt_next = res_cnt_reg + 1'b1;
        end
        else if (res_pop && !s_valid_reg)
        begin
            res_cnt_next = res_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_wr_ptr_reg <= '0;
            res_rd_ptr_reg <= '0;
            res_cnt_reg    <= '0;
        end
        else
        begin
            res_cnt_reg <= res_cnt_next;
            if (s_valid_reg)
            begin
                res_wr_ptr_reg <= (res_wr_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0
                                  : res_wr_ptr_reg + 1'b1;
            end
            if (res_pop)
            begin
                res_rd_ptr_reg <= (res_rd_ptr_reg == RES_PTR_W'(RES_DEPTH - 1)) ? '0
                                  : res_rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid_reg)
        begin
            res_slot_reg[res_wr_ptr_reg] <= res_item;
        end
    end

    a_res_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        ({1'b0, res_cnt_reg} + (RES_CNT_W + 1)'(s_valid_reg))
            <= (RES_CNT_W + 1)'(RES_DEPTH))
        else $error("result queue overcommitted");

    a_clear_takes: assert property (@(posedge clk) disable iff (!rst_n)
        (issue_word && cmd.clear) |=> (row_valid_reg == '0) && !valid_flag_reg)
        else $error("packet start did not clear store and valid flag");

    a_bad_packet_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !result.packet_ok) |->
            (result.tdc_value == '0) && !result.trigger_bit
            && (result.channel_count == '0) && (result.module_address == '0))
        else $error("result of invalid packet carries data");

    a_stage_from_read: assert property (@(posedge clk) disable iff (!rst_n)
        s_valid_reg |-> $past(issue_read))
        else $error("read stage loaded without a read");

endmodule

// ===== tb/sv/trd_readback_checker.sv =====
// Readback checker for the TDC readout packet decoder: tracks decoder state and compares reads.
module trd_readback_checker
    import trd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  logic      full,
    input  in_item_t  item,
    input  logic      empty,
    input  logic      pop,
    input  out_item_t result,
    output int        mismatches,
    output int        reads_pending
);

    logic [6:0]  chan_mem [CHAN_LIMIT];
    logic [1:0]  word_idx;
    logic        fmt_flag;
    logic [11:0] hdr_val [3];
    logic [17:0] trailer_q;
    logic        pkt_valid;
    out_item_t   readback_q [$];
    int          err_cnt = 0;

    function automatic void clear_packet();
        foreach (chan_mem[i]) chan_mem[i] = CHAN_CLEAR;
        foreach (hdr_val[i]) hdr_val[i] = '0;
        pkt_valid = 1'b0;
    endfunction

    function automatic void decode_word(input logic [31:0] w, input logic lst);
        logic [1:0] pos;
        logic [5:0] addr;
        int         base;
        pos = word_idx;
        if (pos == 2'd0)
        begin
            clear_packet();
            fmt_flag = w[30];
        end
        if (pos <= 2'd2)
        begin
            if (fmt_flag && w[29])
            begin
                case (w[15:12])
                    TAG_MODULE: hdr_val[HDR_MODULE] = w[11:0];
                    TAG_EVENT:  hdr_val[HDR_EVENT]  = w[11:0];
                    TAG_CLOCK:  hdr_val[HDR_CLOCK]  = w[11:0];
                    default: ;
                endcase
            end
        end
        else if (!lst && fmt_flag)
        begin
            addr = w[26:21];
            // fpga address 6..31 only; module counts down from address 31
            if (addr >= FPGA_ADDR_MIN && !addr[5])
            begin
                base = ((31 - int'(addr)) >> 1) * 64 + 2 * int'(w[20:16]);
                if (base < CHAN_LIMIT)
                    chan_mem[base] = {w[12], w[5:0]};
                if (base + 1 < CHAN_LIMIT)
                    chan_mem[base + 1] = {w[13], w[11:6]};
            end
        end
        if (lst)
        begin
            pkt_valid = w[31] && (pos >= 2'd2);
            trailer_q = w[17:0];
            word_idx  = 2'd0;
        end
        else if (pos < 2'd3)
            word_idx = pos + 2'd1;
    endfunction

    function automatic out_item_t channel_readback(input logic [9:0] ch);
        out_item_t r;
        r = '0;
        if (pkt_valid)
        begin
            if (ch < CHAN_LIMIT)
                {r.trigger_bit, r.tdc_value} = chan_mem[ch];
            r.packet_ok      = 1'b1;
            r.module_address = hdr_val[HDR_MODULE];
            r.event_number   = hdr_val[HDR_EVENT];
            r.clock_number   = hdr_val[HDR_CLOCK];
            r.parity_word    = trailer_q[15:0];
            r.parity_good    = trailer_q[16];
            r.event_match    = trailer_q[17];
            r.channel_count  = CHAN_COUNT;
        end
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_cnt++;
        end
    endfunction

    function automatic void compare_result(input out_item_t want, input out_item_t got);
        check_field("tdc_value", want.tdc_value, got.tdc_value);
        check_field("trigger_bit", want.trigger_bit, got.trigger_bit);
        check_field("packet_ok", want.packet_ok, got.packet_ok);
        check_field("module_address", want.module_address, got.module_address);
        check_field("event_number", want.event_number, got.event_number);
        check_field("clock_number", want.clock_number, got.clock_number);
        check_field("parity_word", want.parity_word, got.parity_word);
        check_field("parity_good", want.parity_good, got.parity_good);
        check_field("event_match", want.event_match, got.event_match);
        check_field("channel_count", want.channel_count, got.channel_count);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_packet();
            word_idx  = 2'd0;
            fmt_flag  = 1'b0;
            trailer_q = '0;
            readback_q.delete();
            err_cnt = 0;
            mismatches    <= 0;
            reads_pending <= 0;
        end
        else
        begin
            // pop side first so a stray result never pairs with a read taken this cycle
            if (pop && !empty)
            begin
                if (readback_q.size() == 0)
                begin
                    $error("result item with no read outstanding");
                    err_cnt++;
                end
                else
                    compare_result(readback_q.pop_front(), result);
            end
            if (push && !full)
            begin
                if (item.op == OP_READ)
                    readback_q.push_back(channel_readback(item.channel));
                else
                    decode_word(item.data_word, item.last);
            end
            mismatches    <= err_cnt;
            reads_pending <= readback_q.size();
        end
    end

endmodule

// ===== tb/sv/tb_tdc_readout_packet_decoder.sv =====
// Testbench top for the TDC readout packet decoder: stimulus, idling and verdict.
module tb_tdc_readout_packet_decoder;
    import trd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int ITEM_TARGET = 740;

    typedef enum int {PKT_GOOD, PKT_SHORT, PKT_BAD_TRAILER, PKT_NO_FORMAT} pkt_kind_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    in_item_t  item;
    logic      empty;
    logic      pop;
    out_item_t result;

    int mismatches;
    int reads_pending;
    int items_sent = 0;
    int cycle_cnt = 0;
    bit push_burst = 1'b0;
    bit pop_burst = 1'b0;
    int chan_targets [$];

    tdc_readout_packet_decoder DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    trd_readback_checker readback_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .item          (item),
        .empty         (empty),
        .pop           (pop),
        .result        (result),
        .mismatches    (mismatches),
        .reads_pending (reads_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int draw_gap(input bit burst);
        return burst ? 0 : $urandom_range(0, 4);
    endfunction

    function automatic logic [3:0] tag_of(input int k);
        case (k % 3)
            0: return TAG_MODULE;
            1: return TAG_EVENT;
            default: return TAG_CLOCK;
        endcase
    endfunction

    // data word that lands on the channel pair holding channel c
    function automatic logic [31:0] pair_word(input int c);
        logic [31:0] w;
        int          m;
        m = c / 64;
        w = $urandom;
        w[26:21] = 6'(31 - 2 * m - $urandom_range(0, 1));
        w[20:16] = 5'((c % 64) / 2);
        return w;
    endfunction

    function automatic logic [9:0] pick_chan();
        int k;
        k = $urandom_range(0, 9);
        if (k < 7 && chan_targets.size() > 0)
            return 10'(chan_targets[$urandom_range(0, chan_targets.size() - 1)]
                       ^ $urandom_range(0, 1));
        if (k < 9)
            return 10'($urandom_range(0, CHAN_LIMIT - 1));
        return 10'($urandom_range(CHAN_LIMIT, 1023));
    endfunction

    function automatic int data_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(0, 12);
    endfunction

    task automatic send(input logic op_code, input logic [31:0] word, input logic lst,
                        input logic [9:0] chan);
        int gap;
        gap = draw_gap(push_burst);
        while (gap > 0)
        begin
            push <= 1'b0;
            @(posedge clk);
            gap--;
        end
        push <= 1'b1;
        item <= '{op: op_code, data_word: word, last: lst, channel: chan};
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic push_word(input logic [31:0] word, input logic lst);
        send(OP_PUSH, word, lst, 10'($urandom));
    endtask

    task automatic read_chan(input logic [9:0] chan);
        send(OP_READ, $urandom, 1'($urandom), chan);
    endtask

    // hold the sender until every read has come back
    task automatic drain();
        push <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (reads_pending != 0);
    endtask

    task automatic packet(input pkt_kind_t kind, input int n_data);
        logic [31:0] w;
        int          c;
        int          n_hdr;
        int          rot;
        chan_targets.delete();
        rot   = $urandom_range(0, 2);
        n_hdr = (kind == PKT_SHORT) ? $urandom_range(0, 1) : 3;
        for (int i = 0; i < n_hdr; i++)
        begin
            w = $urandom;
            w[29]    = 1'b1;
            w[15:12] = tag_of(rot + i);
            if (i == 0)
                w[30] = (kind != PKT_NO_FORMAT);
            if ($urandom_range(0, 7) == 0)
                w[29] = 1'b0;
            else if ($urandom_range(0, 7) == 0)
                w[15:12] = 4'($urandom);
            push_word(w, 1'b0);
            if ($urandom_range(0, 9) == 0)
                read_chan(pick_chan());
        end
        if (kind != PKT_SHORT)
        begin
            for (int i = 0; i < n_data; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    w = $urandom;
                else
                begin
                    c = $urandom_range(0, CHAN_LIMIT - 1);
                    chan_targets.push_back(c);
                    w = pair_word(c);
                end
                push_word(w, 1'b0);
                if ($urandom_range(0, 19) == 0)
                    read_chan(pick_chan());
            end
        end
        w = $urandom;
        if (kind == PKT_BAD_TRAILER)
            w[31] = 1'b0;
        else if (kind != PKT_SHORT)
            w[31] = 1'b1;
        push_word(w, 1'b1);
    endtask

    initial
    begin
        int pick;
        rst_n <= 1'b0;
        push  <= 1'b0;
        item  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: nothing decoded yet
        read_chan(10'd0);
        // full header, corner pairs, addresses just outside the window
        push_word({16'h6000, TAG_MODULE, 12'hFFF}, 1'b0);
        push_word({16'h2000, TAG_EVENT, 12'h000}, 1'b0);
        push_word({16'h2000, TAG_CLOCK, 12'($urandom)}, 1'b0);
        push_word({5'b0, 6'd6, 5'd31, 4'hF, 12'hFFF}, 1'b0);
        push_word({5'b0, 6'd31, 5'd0, 4'h0, 12'h000}, 1'b0);
        push_word({5'b0, 6'd5, 5'd0, 4'hF, 12'hABC}, 1'b0);
        push_word({5'b0, 6'd32, 5'd3, 4'hF, 12'h123}, 1'b0);
        push_word({1'b1, 13'($urandom), 18'h3FFFF}, 1'b1);
        read_chan(10'd831);
        read_chan(10'd830);
        read_chan(10'd0);
        read_chan(10'd2);
        read_chan(10'd832);
        read_chan(10'd1023);
        // two-word packet, read while it is open
        push_word({16'h6000, TAG_EVENT, 12'h5A5}, 1'b0);
        read_chan(10'd0);
        push_word({1'b1, 31'($urandom)}, 1'b1);
        read_chan(10'd830);
        // format flag clear: headers and data are not decoded
        push_word({16'h2000, TAG_MODULE, 12'h777}, 1'b0);
        push_word({16'h2000, TAG_EVENT, 12'h111}, 1'b0);
        push_word($urandom, 1'b0);
        push_word({5'b0, 6'd6, 5'd31, 4'hF, 12'hFFF}, 1'b0);
        push_word({1'b1, 31'($urandom)}, 1'b1);
        read_chan(10'd830);
        // trailer as the only word
        push_word({1'b1, 31'($urandom)}, 1'b1);
        read_chan(10'd1);
        drain();

        while (items_sent < ITEM_TARGET)
        begin
            push_burst = ($urandom_range(0, 4) == 0);
            pick = $urandom_range(0, 19);
            if (pick < 13)
                packet(PKT_GOOD, data_len());
            else if (pick < 15)
                packet(PKT_SHORT, 0);
            else if (pick < 16)
                packet(PKT_BAD_TRAILER, data_len());
            else if (pick < 17)
                packet(PKT_NO_FORMAT, data_len());
            else
            begin
                repeat ($urandom_range(1, 4))
                    send(1'($urandom), $urandom, 1'($urandom), 10'($urandom));
            end
            repeat ($urandom_range(1, 6))
                read_chan(pick_chan());
            if ($urandom_range(0, 19) == 0)
                drain();
        end

        drain();
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // result side: random stall before each item, none while pop_burst is set
    initial
    begin
        int gap;
        gap = 0;
        pop <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
            begin
                gap = draw_gap(pop_burst);
                if ($urandom_range(0, 29) == 0)
                    pop_burst = !pop_burst;
            end
            if (gap > 0)
            begin
                pop <= 1'b0;
                gap--;
            end
            else
                pop <= 1'b1;
        end
    end

endmodule

// ===== tdc_readout_packet_decoder.f =====
rtl/trd_pkg.sv
rtl/trd_front.sv
rtl/trd_cmd_queue.sv
rtl/trd_back.sv
rtl/tdc_readout_packet_decoder.sv
tb/sv/trd_readback_checker.sv
tb/sv/tb_tdc_readout_packet_decoder.sv
